[design/mms_pkg.sv]
// shared types, constants and hash step for the minimizer sketch
package mms_pkg;

    localparam int KMER_W  = 56;
    localparam int KEY_W   = 64;
    localparam int LOC_W   = 32;
    localparam int POS_W   = 31;
    localparam int SPAN_W  = 5;
    localparam int SEQ_W   = 16;
    localparam int CFG_W   = 5;
    localparam int VRUN_W  = 6;
    localparam int ENT_W   = KEY_W + LOC_W;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int MAX_KMER       = 28;

    localparam logic [CFG_W-1:0] RST_WINDOW = 5'd10;
    localparam logic [CFG_W-1:0] RST_KMER   = 5'd15;

    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_KMER   = 2'd1,
        REG_STRAND = 2'd2,
        REG_SEQID  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_WRITE,
        ST_RD,
        ST_CHK,
        ST_POST,
        ST_MAIN,
        ST_END,
        ST_LAST,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SCAN_TIES_X,
        SCAN_RESCAN,
        SCAN_TIES_I
    } t_scan_mode;

    localparam logic [2:0] HASH_LAST_STEP = 3'd6;

    // one step of the invertible integer hash, masked to 2k bits
    function automatic logic [KMER_W-1:0] hash_step(input logic [KMER_W-1:0] v,
                                                   input logic [2:0] step,
                                                   input logic [KMER_W-1:0] m);
        logic [KMER_W-1:0] r;
        case (step)
            3'd0:    r = (~v + (v << 21)) & m;
            3'd1:    r = v ^ (v >> 24);
            3'd2:    r = (v + (v << 3) + (v << 8)) & m;
            3'd3:    r = v ^ (v >> 14);
            3'd4:    r = (v + (v << 2) + (v << 4)) & m;
            3'd5:    r = v ^ (v >> 28);
            default: r = (v + (v << 31)) & m;
        endcase
        return r;
    endfunction

endpackage

[design/minimizer_sketch.sv]
// top level of the streaming (w,k)-minimizer sketch
//
// Takes one nucleotide per transfer (codes 0..3 = A,C,G,T, 4..7 ambiguous) and
// emits the symmetric (w,k)-minimizers of the sequence, ties included, as
// result transfers carrying hash, span, sequence id, end position and strand;
// tlast on the result side marks the last result caused by one base. One base
// is worked on at a time and s_tready is high only between bases. A base whose
// k-mer is symmetric is skipped; a base that yields a k-mer first runs the
// 7-step hash, one step a cycle, before it enters the window; the last base
// of a sequence adds a final flush. Each window scan reads, then checks, each
// entry it visits (pos+1 .. w-1, then 0 .. pos): a tie scan when the run first
// fills the window, and a minimum rescan followed by a tie scan when the
// minimum leaves the window, with the post state between those two, so up to
// three passes per base; stalls on the result side hold the work up. The
// window lives in a one-port-read ram with per-entry valid bits; a cleared
// entry reads as empty, so reset and the last base clear the window at once
// with no sweep. Configuration must be written over the apb port only while
// no base is in flight; the block itself does not enforce this.
module minimizer_sketch
    import mms_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [2:0] base, zero fill above
    input  logic         s_tlast,   // last base of the sequence
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // hash value, span, sequence id, end position
    output logic         m_tuser,   // strand
    output logic         m_tlast,   // last result of this base
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = SW + 1;

    // configuration registers
    logic [CFG_W-1:0] r_window_size;
    logic [CFG_W-1:0] r_kmer_len;
    logic             r_both;
    logic [SEQ_W-1:0] r_seq_id;

    // sketch state
    logic [KMER_W-1:0] r_fwd, r_rev;
    logic [VRUN_W-1:0] r_vrun;
    logic [SW-1:0]     r_wslot, r_min_slot, r_pos;
    logic [KEY_W-1:0]  r_min_key;
    logic [LOC_W-1:0]  r_min_loc;
    logic [POS_W-1:0]  r_base;
    logic              r_valid [MAX_WINDOW];

    // per-base work registers
    t_state            r_state, n_state;
    logic [KMER_W-1:0] r_hv;
    logic [2:0]        r_hstep;
    logic              r_has_key, r_z, r_skip, r_last;
    logic [SPAN_W-1:0] r_span;
    logic [KEY_W-1:0]  r_cur_key;
    logic [LOC_W-1:0]  r_cur_loc;

    // window scan
    t_scan_mode r_mode;
    logic [WW-1:0] r_j;
    logic          r_phase;
    logic          r_rdv;

    // result hold stage and output register
    logic              r_hold_valid;
    logic [KEY_W-1:0]  r_hold_key;
    logic [LOC_W-1:0]  r_hold_loc;
    logic              r_out_valid, r_out_last;
    logic [KEY_W-1:0]  r_out_key;
    logic [LOC_W-1:0]  r_out_loc;

    // effective window and k-mer length
    logic [CFG_W-1:0]  w_cl, k_eff;
    logic [WW-1:0]     w_eff;
    logic [KMER_W-1:0] mask;
    logic [6:0]        thr, vrun7;

    assign w_cl  = (r_window_size == '0) ? 5'd1 :
                   (r_window_size > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : r_window_size;
    assign w_eff = WW'(w_cl);
    assign k_eff = (r_kmer_len == '0) ? 5'd1 :
                   (r_kmer_len > 5'(MAX_KMER)) ? 5'(MAX_KMER) : r_kmer_len;
    assign mask  = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
    assign thr   = 7'(w_eff) + 7'(k_eff) - 7'd1;   // w + k - 1
    assign vrun7 = {1'b0, r_vrun};

    // base intake: k-mer shift, strand choice, run length
    logic [1:0]        nt;
    logic              amb, sym, z_new, skip_new, has_key_new;
    logic [KMER_W-1:0] fwd_new, rev_new;
    logic [VRUN_W-1:0] vrun_new;
    logic [SPAN_W-1:0] span_new;
    logic              accept;

    assign nt       = s_tdata[1:0];
    assign amb      = s_tdata[2];
    assign fwd_new  = ((r_fwd << 2) | KMER_W'(nt)) & mask;
    assign rev_new  = (r_rev >> 2) | (KMER_W'(2'b11 ^ nt) << ({1'b0, k_eff, 1'b0} - 7'd2));
    assign sym      = r_both && (fwd_new == rev_new);
    assign z_new    = r_both && !(fwd_new < rev_new);
    assign skip_new = !amb && sym;
    assign span_new = (vrun7 + 7'd1 < 7'(k_eff)) ? SPAN_W'(r_vrun + 6'd1) : k_eff;
    assign vrun_new = amb ? '0 : skip_new ? r_vrun :
                      (r_vrun == '1) ? r_vrun : r_vrun + 6'd1;
    assign has_key_new = !amb && !skip_new && ({1'b0, vrun_new} >= 7'(k_eff));
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE);

    // key of this base as it enters the window
    logic [KEY_W-1:0] cur_key;
    logic [LOC_W-1:0] cur_loc;
    assign cur_key = r_has_key ? {r_hv, 3'b000, r_span} : '1;
    assign cur_loc = r_has_key ? {r_base, r_z} : '1;

    // window memory
    logic [ENT_W-1:0] ram_q;
    logic [KEY_W-1:0] ent_key;
    logic [LOC_W-1:0] ent_loc;

    mms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW),
        .AW    (SW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WRITE),
        .i_waddr (r_pos),
        .i_wdata ({cur_key, cur_loc}),
        .i_raddr (r_j[SW-1:0]),
        .o_rdata (ram_q)
    );

    assign ent_key = r_rdv ? ram_q[ENT_W-1:LOC_W] : '1;
    assign ent_loc = r_rdv ? ram_q[LOC_W-1:0] : '1;

    // scan order: pos+1 .. w-1, then 0 .. pos
    logic [WW-1:0] scan_j0, scan_jn;
    logic          scan_p0, scan_pn, scan_last;
    assign scan_p0   = !((WW'(r_pos) + 1'b1) < w_eff);
    assign scan_j0   = scan_p0 ? '0 : WW'(r_pos) + 1'b1;
    assign scan_pn   = r_phase || !((r_j + 1'b1) < w_eff);
    assign scan_jn   = (!r_phase && scan_pn) ? '0 : r_j + 1'b1;
    assign scan_last = r_phase && (r_j == WW'(r_pos));

    logic min_empty, tie_match, rescan_upd, main_le, main_evict, main_emit;
    assign min_empty  = (r_min_key == '1);
    assign tie_match  = (r_mode != SCAN_RESCAN) && (ent_key == r_min_key) &&
                        (ent_loc != r_min_loc) &&
                        !((r_mode == SCAN_TIES_X) && (r_j == WW'(r_pos)));
    assign rescan_upd = (r_mode == SCAN_RESCAN) && (r_min_key >= ent_key);
    assign main_le    = (r_cur_key <= r_min_key);
    assign main_evict = !main_le && (r_pos == r_min_slot);
    assign main_emit  = !min_empty && (main_le ? (vrun7 >= thr + 7'd1)
                                               : (main_evict && (vrun7 >= thr)));

    // emission into the hold stage; the held result learns its tlast later
    logic             out_free, can_emit, emit_req, emit_fire, flush_fire;
    logic [KEY_W-1:0] emit_key;
    logic [LOC_W-1:0] emit_loc;
    assign out_free = !r_out_valid || m_tready;
    assign can_emit = !r_hold_valid || out_free;

    always_comb begin
        n_state  = r_state;
        emit_req = 1'b0;
        emit_key = r_min_key;
        emit_loc = r_min_loc;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = skip_new ? ST_END : has_key_new ? ST_HASH : ST_WRITE;
                end
            end
            ST_HASH: begin
                if (r_hstep == HASH_LAST_STEP) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ((vrun7 == thr) && !min_empty) ? ST_RD : ST_MAIN;
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                emit_req = tie_match;
                emit_key = ent_key;
                emit_loc = ent_loc;
                if (!(tie_match && !can_emit)) begin
                    if (!scan_last) begin
                        n_state = ST_RD;
                    end else begin
                        unique case (r_mode)
                            SCAN_TIES_X: n_state = ST_MAIN;
                            SCAN_RESCAN: n_state = ST_POST;
                            default:     n_state = ST_END;
                        endcase
                    end
                end
            end
            ST_POST: begin
                n_state = ((vrun7 >= thr) && !min_empty) ? ST_RD : ST_END;
            end
            ST_MAIN: begin
                emit_req = main_emit;
                if (!main_emit || can_emit) begin
                    n_state = (!main_le && main_evict) ? ST_RD : ST_END;
                end
            end
            ST_END: begin
                n_state = r_last ? ST_LAST : ST_FLUSH;
            end
            ST_LAST: begin
                emit_req = !min_empty;
                if (min_empty || can_emit) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign emit_fire  = emit_req && can_emit;
    assign flush_fire = (r_state == ST_FLUSH) && r_hold_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sketch state and per-base work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= '0;
            r_rev      <= '0;
            r_vrun     <= '0;
            r_wslot    <= '0;
            r_min_slot <= '0;
            r_min_key  <= '1;
            r_min_loc  <= '1;
            r_base     <= '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_pos     <= r_wslot;
                        r_hv      <= z_new ? rev_new : fwd_new;
                        r_hstep   <= '0;
                        r_has_key <= has_key_new;
                        r_z       <= z_new;
                        r_skip    <= skip_new;
                        r_last    <= s_tlast;
                        r_span    <= span_new;
                        r_vrun    <= vrun_new;
                        if (!amb) begin
                            r_fwd <= fwd_new;
                            if (r_both) begin
                                r_rev <= rev_new;
                            end
                        end
                    end
                end
                ST_HASH: begin
                    r_hv    <= hash_step(r_hv, r_hstep, mask);
                    r_hstep <= r_hstep + 3'd1;
                end
                ST_WRITE: begin
                    r_cur_key      <= cur_key;
                    r_cur_loc      <= cur_loc;
                    r_valid[r_pos] <= 1'b1;
                    r_mode         <= SCAN_TIES_X;
                    r_j            <= scan_j0;
                    r_phase        <= scan_p0;
                end
                ST_RD: begin
                    r_rdv <= r_valid[r_j[SW-1:0]];
                end
                ST_CHK: begin
                    if (!(tie_match && !can_emit)) begin
                        r_j     <= scan_jn;
                        r_phase <= scan_pn;
                        if (rescan_upd) begin
                            r_min_key  <= ent_key;
                            r_min_loc  <= ent_loc;
                            r_min_slot <= r_j[SW-1:0];
                        end
                    end
                end
                ST_POST: begin
                    r_mode  <= SCAN_TIES_I;
                    r_j     <= scan_j0;
                    r_phase <= scan_p0;
                end
                ST_MAIN: begin
                    if (!main_emit || can_emit) begin
                        if (main_le) begin
                            r_min_key  <= r_cur_key;
                            r_min_loc  <= r_cur_loc;
                            r_min_slot <= r_pos;
                        end else if (main_evict) begin
                            // minimum left the window: rescan from scratch
                            r_min_key <= '1;
                            r_min_loc <= '1;
                            r_mode    <= SCAN_RESCAN;
                            r_j       <= scan_j0;
                            r_phase   <= scan_p0;
                        end
                    end
                end
                ST_END: begin
                    r_base <= r_base + 1'b1;
                    if (!r_skip) begin
                        r_wslot <= ((WW'(r_pos) + 1'b1) >= w_eff) ? '0 : r_pos + 1'b1;
                    end
                end
                ST_LAST: begin
                    if (min_empty || can_emit) begin
                        r_fwd      <= '0;
                        r_rev      <= '0;
                        r_vrun     <= '0;
                        r_wslot    <= '0;
                        r_min_slot <= '0;
                        r_min_key  <= '1;
                        r_min_loc  <= '1;
                        r_base     <= '0;
                        for (int i = 0; i < MAX_WINDOW; i++) begin
                            r_valid[i] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // hold stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (emit_fire) begin
            if (r_hold_valid) begin
                r_out_valid <= 1'b1;
                r_out_key   <= r_hold_key;
                r_out_loc   <= r_hold_loc;
                r_out_last  <= 1'b0;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_hold_valid <= 1'b1;
            r_hold_key   <= emit_key;
            r_hold_loc   <= emit_loc;
        end else if (flush_fire) begin
            r_out_valid  <= 1'b1;
            r_out_key    <= r_hold_key;
            r_out_loc    <= r_hold_loc;
            r_out_last   <= 1'b1;
            r_hold_valid <= 1'b0;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_out_loc[LOC_W-1:1], r_seq_id,
                       r_out_key[SPAN_W-1:0], r_out_key[KEY_W-1:8]};
    assign m_tuser  = r_out_loc[0];
    assign m_tlast  = r_out_last;

    // configuration port
    logic     cfg_wr;
    t_reg_idx cfg_idx;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= RST_WINDOW;
            r_kmer_len    <= RST_KMER;
            r_both        <= 1'b1;
            r_seq_id      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WINDOW: r_window_size <= pwdata[CFG_W-1:0];
                REG_KMER:   r_kmer_len    <= pwdata[CFG_W-1:0];
                REG_STRAND: r_both        <= pwdata[0];
                REG_SEQID:  r_seq_id      <= pwdata[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WINDOW: prdata = 32'(r_window_size);
            REG_KMER:   prdata = 32'(r_kmer_len);
            REG_STRAND: prdata = 32'(r_both);
            REG_SEQID:  prdata = 32'(r_seq_id);
            default:    prdata = '0;
        endcase
    end

endmodule

[design/mms_ram.sv]
// generic single write port ram with registered read
module mms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
